// ----- hw/rtl/crn_pkg.sv -----
// Shared types, register indexes and crop geometry helpers for the crop, resize,
// normalize and quantize core. No dependencies.
package crn_pkg;

    localparam int POS_W            = 7;
    localparam int SIDE_W           = 12;
    localparam int QEXP_W           = 5;
    localparam int OUT_SIZE_DEF     = 96;
    localparam int COEF_FRAC_DEF    = 16;
    localparam int QUEUE_DEPTH_DEF  = 4;

    localparam logic [SIDE_W-1:0]        RST_WIDTH  = 12'd320;
    localparam logic [SIDE_W-1:0]        RST_HEIGHT = 12'd240;
    localparam logic signed [QEXP_W-1:0] RST_QEXP   = -5'sd5;

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_QEXP   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [SIDE_W-1:0]        width;
        logic [SIDE_W-1:0]        height;
        logic signed [QEXP_W-1:0] qexp;
    } t_cfg;

    typedef struct packed {
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             done;
    } t_tag;

    typedef struct packed {
        t_tag        tag;
        logic [15:0] pixel;
    } t_item;

    function automatic logic [SIDE_W-1:0] f_eff_side(logic [SIDE_W-1:0] v, int out_size);
        logic [SIDE_W-1:0] lim;
        lim = SIDE_W'(out_size);
        return (v < lim) ? lim : v;
    endfunction

    function automatic logic [SIDE_W-1:0] f_origin(logic [SIDE_W-1:0] a, logic [SIDE_W-1:0] b,
                                                   int out_size);
        logic [SIDE_W-1:0] ea;
        logic [SIDE_W-1:0] eb;
        logic [SIDE_W-1:0] crop;
        ea   = f_eff_side(a, out_size);
        eb   = f_eff_side(b, out_size);
        crop = (ea < eb) ? ea : eb;
        return (ea - crop) >> 1;
    endfunction

endpackage

// ----- hw/rtl/crn_front.sv -----
// Front part: crop geometry registers, source/output counters and pixel selection.
// Pushes selected pixels into the queue. Depends on crn_pkg.
module crn_front import crn_pkg::*; #(
    parameter int OUT_SIZE = OUT_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_cfg_wr,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_pixel,
    input  logic        i_frame_start,
    input  logic        i_full,
    output logic        o_push,
    output t_item       o_item
);

    localparam int RECIP_SH = 20;
    localparam int MW       = RECIP_SH - 2;
    localparam int QW       = $clog2(4095 / OUT_SIZE + 1);
    localparam logic [MW-1:0]     RECIP     = MW'((1 << RECIP_SH) / OUT_SIZE);
    localparam logic [SIDE_W-1:0] OUT_S     = SIDE_W'(OUT_SIZE);
    localparam logic [POS_W-1:0]  OUT_P     = POS_W'(OUT_SIZE);
    localparam logic [POS_W-1:0]  LAST_P    = POS_W'(OUT_SIZE - 1);
    localparam logic [POS_W:0]    OUT_SUM   = (POS_W + 1)'(OUT_SIZE);
    localparam logic [SIDE_W-1:0] RST_ORG_C = f_origin(RST_WIDTH, RST_HEIGHT, OUT_SIZE);
    localparam logic [SIDE_W-1:0] RST_ORG_R = f_origin(RST_HEIGHT, RST_WIDTH, OUT_SIZE);
    localparam logic [1:0]        SETTLE    = 2'd2;

    logic [SIDE_W-1:0]    eff_w;
    logic [SIDE_W-1:0]    eff_h;
    logic [SIDE_W-1:0]    crop;
    logic [SIDE_W-1:0]    r_crop;
    logic [SIDE_W-1:0]    r_org_col;
    logic [SIDE_W-1:0]    r_org_row;
    logic [SIDE_W-1:0]    r_sw_m1;
    logic [SIDE_W+MW-1:0] r_prod;
    logic [QW-1:0]        q_est;
    logic [SIDE_W-1:0]    rem_est;
    logic [QW-1:0]        r_q;
    logic [POS_W-1:0]     r_rem;
    logic [1:0]           r_settle;

    logic [SIDE_W-1:0] r_src_col, r_src_row, r_want_col, r_want_row;
    logic [POS_W-1:0]  r_dst_col, r_dst_row, r_col_rem, r_row_rem;
    logic [SIDE_W-1:0] n_src_col, n_src_row, n_want_col, n_want_row;
    logic [POS_W-1:0]  n_dst_col, n_dst_row, n_col_rem, n_row_rem;

    logic [SIDE_W-1:0] sc, sr, wc, wr, wc_step, wr_step;
    logic [POS_W-1:0]  dc, dr, crem, rrem;
    logic [POS_W:0]    col_sum, row_sum;
    logic              row_sel, emit, accept;

    // geometry, stage A
    always_comb begin
        eff_w = f_eff_side(i_cfg.width, OUT_SIZE);
        eff_h = f_eff_side(i_cfg.height, OUT_SIZE);
        crop  = (eff_w < eff_h) ? eff_w : eff_h;
    end

    always_ff @(posedge i_clk) begin
        r_crop    <= crop;
        r_org_col <= (eff_w - crop) >> 1;
        r_org_row <= (eff_h - crop) >> 1;
        r_sw_m1   <= eff_w - 12'd1;
        r_prod    <= (SIDE_W + MW)'(crop) * (SIDE_W + MW)'(RECIP);
    end

    // geometry, stage B: reciprocal quotient with one correction step
    always_comb begin
        q_est   = r_prod[RECIP_SH +: QW];
        rem_est = r_crop - SIDE_W'(SIDE_W'(q_est) * OUT_S);
    end

    always_ff @(posedge i_clk) begin
        if (rem_est >= OUT_S) begin
            r_q   <= q_est + QW'(1);
            r_rem <= POS_W'(rem_est - OUT_S);
        end else begin
            r_q   <= q_est;
            r_rem <= POS_W'(rem_est);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= SETTLE;
        end else if (i_cfg_wr) begin
            r_settle <= SETTLE;
        end else if (r_settle != 2'd0) begin
            r_settle <= r_settle - 2'd1;
        end
    end

    assign o_in_stall = (r_settle != 2'd0) || i_full;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        sc   = i_frame_start ? '0 : r_src_col;
        sr   = i_frame_start ? '0 : r_src_row;
        dc   = i_frame_start ? '0 : r_dst_col;
        dr   = i_frame_start ? '0 : r_dst_row;
        wc   = i_frame_start ? r_org_col : r_want_col;
        wr   = i_frame_start ? r_org_row : r_want_row;
        crem = i_frame_start ? '0 : r_col_rem;
        rrem = i_frame_start ? '0 : r_row_rem;

        row_sel = (sr == wr) && (dr < OUT_P);
        emit    = row_sel && (sc == wc) && (dc < OUT_P);

        col_sum = {1'b0, crem} + {1'b0, r_rem};
        row_sum = {1'b0, rrem} + {1'b0, r_rem};
        wc_step = wc + SIDE_W'(r_q);
        wr_step = wr + SIDE_W'(r_q);

        n_src_col  = sc;
        n_src_row  = sr;
        n_dst_col  = dc;
        n_dst_row  = dr;
        n_want_col = wc;
        n_want_row = wr;
        n_col_rem  = crem;
        n_row_rem  = rrem;

        if (emit) begin
            n_dst_col = dc + POS_W'(1);
            if (col_sum >= OUT_SUM) begin
                n_col_rem  = POS_W'(col_sum - OUT_SUM);
                n_want_col = wc_step + 12'd1;
            end else begin
                n_col_rem  = POS_W'(col_sum);
                n_want_col = wc_step;
            end
        end

        if (sc >= r_sw_m1) begin
            n_src_col = '0;
            n_src_row = sr + 12'd1;
            if (row_sel) begin
                n_dst_row = dr + POS_W'(1);
                if (row_sum >= OUT_SUM) begin
                    n_row_rem  = POS_W'(row_sum - OUT_SUM);
                    n_want_row = wr_step + 12'd1;
                end else begin
                    n_row_rem  = POS_W'(row_sum);
                    n_want_row = wr_step;
                end
            end
            n_dst_col  = '0;
            n_want_col = r_org_col;
            n_col_rem  = '0;
        end else begin
            n_src_col = sc + 12'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_col  <= '0;
            r_src_row  <= '0;
            r_dst_col  <= '0;
            r_dst_row  <= '0;
            r_want_col <= RST_ORG_C;
            r_want_row <= RST_ORG_R;
            r_col_rem  <= '0;
            r_row_rem  <= '0;
        end else if (accept) begin
            r_src_col  <= n_src_col;
            r_src_row  <= n_src_row;
            r_dst_col  <= n_dst_col;
            r_dst_row  <= n_dst_row;
            r_want_col <= n_want_col;
            r_want_row <= n_want_row;
            r_col_rem  <= n_col_rem;
            r_row_rem  <= n_row_rem;
        end
    end

    assign o_push          = accept && emit;
    assign o_item.tag.col  = dc;
    assign o_item.tag.row  = dr;
    assign o_item.tag.done = (dr == LAST_P) && (dc == LAST_P);
    assign o_item.pixel    = i_pixel;

endmodule

// ----- hw/rtl/crn_queue.sv -----
// Short register queue between the front and back parts.
// Depends on crn_pkg.
module crn_queue import crn_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_head,
    input  logic  i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_pop;

    assign o_full  = (r_count == FULL);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ----- hw/rtl/crn_back.sv -----
// Back part: RGB565 expansion, fixed-point normalization and int8 quantization
// in three elastic stages, the last one the output register. Depends on crn_pkg.
module crn_back import crn_pkg::*; #(
    parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic signed [QEXP_W-1:0] i_qexp,
    input  logic                     i_head_valid,
    input  t_item                    i_head,
    output logic                     o_pop,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output t_tag                     o_tag,
    output logic signed [7:0]        o_red_q,
    output logic signed [7:0]        o_green_q,
    output logic signed [7:0]        o_blue_q
);

    localparam int AW = COEF_FRAC_BITS - 4;
    localparam int BW = COEF_FRAC_BITS + 2;
    localparam int PW = COEF_FRAC_BITS + 4;
    localparam int NW = COEF_FRAC_BITS + 6;
    localparam int SW = NW + 4;

    localparam longint unsigned ONE = 64'd1 << COEF_FRAC_BITS;
    localparam logic [AW-1:0] A_R =
        AW'((64'd2 * ONE * 64'd1000 + 64'd58395) / 64'd116790);
    localparam logic [AW-1:0] A_G =
        AW'((64'd2 * ONE * 64'd1000 + 64'd57120) / 64'd114240);
    localparam logic [AW-1:0] A_B =
        AW'((64'd2 * ONE * 64'd1000 + 64'd57375) / 64'd114750);
    localparam logic [BW-1:0] B_R = BW'((64'd2 * ONE * 64'd485 + 64'd229) / 64'd458);
    localparam logic [BW-1:0] B_G = BW'((64'd2 * ONE * 64'd456 + 64'd224) / 64'd448);
    localparam logic [BW-1:0] B_B = BW'((64'd2 * ONE * 64'd406 + 64'd225) / 64'd450);

    // reciprocals of 31 and 63 at 20 fraction bits
    localparam logic [16:0] RCP31 = 17'd33826;
    localparam logic [16:0] RCP63 = 17'd16645;

    function automatic logic [7:0] f_quant(logic [PW-1:0] p, logic [BW-1:0] b,
                                           logic signed [QEXP_W-1:0] e);
        logic signed [NW-1:0] n;
        logic                 neg;
        logic [NW-1:0]        mag;
        logic signed [6:0]    t;
        logic [5:0]           tr;
        logic [6:0]           tn;
        logic [SW-1:0]        sh;
        logic [7:0]           q;
        n   = signed'(NW'(p)) - signed'(NW'(b));
        neg = n[NW-1];
        mag = neg ? NW'(-n) : NW'(n);
        t   = signed'(7'(COEF_FRAC_BITS)) + signed'({{2{e[QEXP_W-1]}}, e});
        tr  = t[5:0];
        tn  = 7'(-t);
        if (t > 7'sd0) begin
            if (t >= 7'(NW)) begin
                sh = '0;
            end else begin
                sh = (SW'(mag) + (SW'(1) << (tr - 6'd1))) >> tr;
            end
        end else begin
            sh = SW'(mag) << tn[2:0];
        end
        if (neg) begin
            q = (sh >= SW'(128)) ? 8'h80 : 8'(8'd0 - sh[7:0]);
        end else begin
            q = (sh > SW'(127)) ? 8'h7F : sh[7:0];
        end
        return q;
    endfunction

    logic en1, en2, en3;

    logic          r_v1;
    t_tag          r1_tag;
    logic [7:0]    r1_r8, r1_g8, r1_b8;
    logic [12:0]   xr, xb;
    logic [13:0]   xg;
    logic [29:0]   pr, pb;
    logic [30:0]   pg;

    logic          r_v2;
    t_tag          r2_tag;
    logic [PW-1:0] r2_pr, r2_pg, r2_pb;

    logic          r_v3;

    assign en3   = !r_v3 || !i_out_stall;
    assign en2   = !r_v2 || en3;
    assign en1   = !r_v1 || en2;
    assign o_pop = i_head_valid && en1;

    always_comb begin
        xr = 13'(i_head.pixel[15:11]) * 13'd255;
        xg = 14'(i_head.pixel[10:5]) * 14'd255;
        xb = 13'(i_head.pixel[4:0]) * 13'd255;
        pr = 30'(xr) * 30'(RCP31);
        pg = 31'(xg) * 31'(RCP63);
        pb = 30'(xb) * 30'(RCP31);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_head_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_tag <= i_head.tag;
            r1_r8  <= pr[27:20];
            r1_g8  <= pg[27:20];
            r1_b8  <= pb[27:20];
        end
        if (en2) begin
            r2_tag <= r1_tag;
            r2_pr  <= PW'(r1_r8) * PW'(A_R);
            r2_pg  <= PW'(r1_g8) * PW'(A_G);
            r2_pb  <= PW'(r1_b8) * PW'(A_B);
        end
        if (en3) begin
            o_tag     <= r2_tag;
            o_red_q   <= signed'(f_quant(r2_pr, B_R, i_qexp));
            o_green_q <= signed'(f_quant(r2_pg, B_G, i_qexp));
            o_blue_q  <= signed'(f_quant(r2_pb, B_B, i_qexp));
        end
    end

    assign o_out_valid = r_v3;

endmodule

// ----- hw/rtl/crop_resize_normalize_quantize_core.sv -----
// A selected pixel is written into the queue, then passes the back stage registers up to the output register.
// Throughput: one pixel per clock; the input stalls while the 4-entry queue is full
// and after reset and after each configuration write while the crop geometry reloads.
// Reset: synchronous, active low; registers return to 320 x 240, exponent -5.
// Top level: configuration registers, front, queue and back. Depends on crn_pkg,
// crn_front, crn_queue and crn_back.
module crop_resize_normalize_quantize_core import crn_pkg::*; #(
    parameter int OUT_SIZE       = OUT_SIZE_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_DEF,
    parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [SIDE_W-1:0]       i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [15:0]             i_pixel,
    input  logic                    i_frame_start,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [POS_W-1:0]        o_out_column,
    output logic [POS_W-1:0]        o_out_row,
    output logic signed [7:0]       o_red_q,
    output logic signed [7:0]       o_green_q,
    output logic signed [7:0]       o_blue_q,
    output logic                    o_frame_done
);

    t_cfg  r_cfg;
    logic  cfg_wr;
    logic  push, full, head_valid, pop;
    t_item push_item, head_item;
    t_tag  out_tag;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= RST_WIDTH;
            r_cfg.height <= RST_HEIGHT;
            r_cfg.qexp   <= RST_QEXP;
        end else if (cfg_wr) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WIDTH:  r_cfg.width  <= i_cfg_data;
                CFG_HEIGHT: r_cfg.height <= i_cfg_data;
                CFG_QEXP:   r_cfg.qexp   <= signed'(i_cfg_data[QEXP_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    crn_front #(
        .OUT_SIZE (OUT_SIZE)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_cfg_wr      (cfg_wr),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .i_full        (full),
        .o_push        (push),
        .o_item        (push_item)
    );

    crn_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .o_valid (head_valid),
        .o_head  (head_item),
        .i_pop   (pop)
    );

    crn_back #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_qexp       (r_cfg.qexp),
        .i_head_valid (head_valid),
        .i_head       (head_item),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_tag        (out_tag),
        .o_red_q      (o_red_q),
        .o_green_q    (o_green_q),
        .o_blue_q     (o_blue_q)
    );

    assign o_out_column = out_tag.col;
    assign o_out_row    = out_tag.row;
    assign o_frame_done = out_tag.done;

`ifndef SYNTHESIS
    a_done_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_done) |->
            (o_out_column == POS_W'(OUT_SIZE - 1)) && (o_out_row == POS_W'(OUT_SIZE - 1)))
        else $error("frame_done away from last position");
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_column < POS_W'(OUT_SIZE)) && (o_out_row < POS_W'(OUT_SIZE)))
        else $error("output position beyond scaled square");
    a_cfg_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> o_in_stall)
        else $error("input taken while crop geometry reloads");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !full)
        else $error("queue push while full");
`endif

endmodule
